FILE: hw/rtl/mpm_pkg.sv
// Shared constants, types and helpers for the multi-pattern case-folding matcher.
// No dependencies; every other file except mpm_ram refers to this package by scoped names.
package mpm_pkg;

  localparam int PATTERN_SLOTS   = 16;
  localparam int PATTERN_MAX_LEN = 32;

  localparam int SLOT_W = (PATTERN_SLOTS > 1) ? $clog2(PATTERN_SLOTS) : 1;
  localparam int POS_W  = $clog2(PATTERN_MAX_LEN);
  localparam int LEN_W  = $clog2(PATTERN_MAX_LEN + 1);
  localparam int BYTE_W = 8;
  localparam int OFF_W  = 32;

  localparam int OP_W       = 2;
  localparam int IN_SLOT_W  = 4;
  localparam int IN_POS_W   = 5;
  localparam int OUT_SLOT_W = 4;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_SCAN  = 2'd1;
  localparam logic [OP_W-1:0] OP_START = 2'd2;

  typedef struct packed {
    logic              take;
    logic              clear_we;
    logic              scan_issue;
    logic              emit_en;
    logic [SLOT_W-1:0] addr;
  } mpm_cmd_t;

  typedef struct packed {
    logic item_valid;
    logic item_scan;
    logic pipe_busy;
    logic mask_empty;
  } mpm_stat_t;

  // Fold ASCII upper case to lower case; zero stays zero.
  function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/mpm_item_if.sv
// Input channel: valid/ready handshake plus one command beat.
// Depends on mpm_pkg for field widths.
interface mpm_item_if;
  logic                           valid;
  logic                           ready;
  logic [mpm_pkg::OP_W-1:0]       operation;
  logic [mpm_pkg::IN_SLOT_W-1:0]  pattern_slot;
  logic [mpm_pkg::IN_POS_W-1:0]   pattern_pos;
  logic [mpm_pkg::BYTE_W-1:0]     byte_value;

  modport source (output valid, operation, pattern_slot, pattern_pos, byte_value,
                  input ready);
  modport sink   (input valid, operation, pattern_slot, pattern_pos, byte_value,
                  output ready);
endinterface

FILE: hw/rtl/mpm_result_if.sv
// Result channel: valid/ready handshake plus one match beat.
// Depends on mpm_pkg for field widths.
interface mpm_result_if;
  logic                            valid;
  logic                            ready;
  logic [mpm_pkg::OUT_SLOT_W-1:0]  match_slot;
  logic [mpm_pkg::OFF_W-1:0]       match_offset;
  logic                            last_match;

  modport source (output valid, match_slot, match_offset, last_match, input ready);
  modport sink   (input valid, match_slot, match_offset, last_match, output ready);
endinterface

FILE: hw/rtl/multi_pattern_nocase_matcher_core.sv
// Top level of the case-folding multi-pattern matcher: controller plus datapath.
// Depends on mpm_pkg, mpm_item_if, mpm_result_if, mpm_ctrl and mpm_datapath.
//
//   channel   direction  handshake      beat contents
//   items     sink       valid/ready    operation, pattern_slot, pattern_pos, byte_value
//   results   source     valid/ready    match_slot, match_offset, last_match
//
// Load and start beats are taken in the idle state, which stays ready. A scan beat
// is accepted, then the sixteen pattern rows are read from the RAM bank one row per
// cycle, the length/compare pipeline drains, result beats go out back to back while
// the results sink is ready, and the pending set is seen empty before idle returns.
// After reset a clearing pass writes zero to every pattern row, with items.ready
// low. A stalled results sink holds the result register and pauses emission; the
// next beat is accepted while the last result still waits.
module multi_pattern_nocase_matcher_core (
  input  logic          clk,
  input  logic          rst,
  mpm_item_if.sink      items,
  mpm_result_if.source  results
);

  mpm_pkg::mpm_cmd_t  cmd;
  mpm_pkg::mpm_stat_t stat;

  // Sequencer: owns the slot counter and decides when beats are taken.
  mpm_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // Datapath: pattern RAM bank, window, compare pipeline and result register.
  mpm_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .items   (items),
    .results (results)
  );

`ifndef SYNTHESIS
  // Hold off new beats while the compare pipeline still has rows in flight.
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    stat.pipe_busy |-> !items.ready)
    else $error("input taken while compare pipeline busy");

  // Pending matches of a byte must all drain before the next beat is taken.
  a_mask_blocks_input: assert property (@(posedge clk) disable iff (rst)
    !stat.mask_empty |-> !items.ready)
    else $error("input taken while matches still pending");

  // A scan beat moves the sequencer into the slot sweep, which drops items.ready.
  a_scan_starts_sweep: assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready && items.operation == mpm_pkg::OP_SCAN)
      |=> (cmd.scan_issue && !items.ready))
    else $error("scan beat did not start the sweep");
`endif

endmodule

FILE: hw/rtl/mpm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/mpm_ctrl.sv
// Sequencer: clear pass, input handshake, slot sweep, drain and result emission.
// Depends on mpm_pkg (command and status structs).
module mpm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  mpm_pkg::mpm_stat_t stat,
  output mpm_pkg::mpm_cmd_t  cmd
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  localparam logic [mpm_pkg::SLOT_W-1:0] CNT_LAST =
    mpm_pkg::SLOT_W'(mpm_pkg::PATTERN_SLOTS - 1);

  logic [2:0]                  state;
  logic [2:0]                  state_next;
  logic [mpm_pkg::SLOT_W-1:0]  cnt;
  logic [mpm_pkg::SLOT_W-1:0]  cnt_next;

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    cmd            = '0;
    cmd.addr       = cnt;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_we = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.take = 1'b1;
        if (stat.item_valid && stat.item_scan) begin
          cnt_next   = '0;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        cnt_next       = cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          cnt_next   = '0;
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit_en = 1'b1;
        if (stat.mask_empty) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
        cnt_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

FILE: hw/rtl/mpm_datapath.sv
// Pattern RAM bank, recent-byte window, byte counter, compare pipeline and result register.
// Depends on mpm_pkg, mpm_item_if, mpm_result_if and mpm_ram.
module mpm_datapath (
  input  logic               clk,
  input  logic               rst,
  input  mpm_pkg::mpm_cmd_t  cmd,
  output mpm_pkg::mpm_stat_t stat,
  mpm_item_if.sink           items,
  mpm_result_if.source       results
);

  localparam int SLOTS   = mpm_pkg::PATTERN_SLOTS;
  localparam int MAX_LEN = mpm_pkg::PATTERN_MAX_LEN;
  localparam int SLOT_W  = mpm_pkg::SLOT_W;
  localparam int POS_W   = mpm_pkg::POS_W;
  localparam int LEN_W   = mpm_pkg::LEN_W;
  localparam int BYTE_W  = mpm_pkg::BYTE_W;
  localparam int OFF_W   = mpm_pkg::OFF_W;

  logic                acc;
  logic                acc_load;
  logic                acc_scan;
  logic                acc_start;
  logic                load_in_range;
  logic [BYTE_W-1:0]   folded_in;

  logic [BYTE_W-1:0]   recent [MAX_LEN];
  logic [OFF_W-1:0]    bytes_seen;

  logic [MAX_LEN-1:0]  ram_we;
  logic [SLOT_W-1:0]   ram_waddr;
  logic [BYTE_W-1:0]   ram_wdata;
  logic [BYTE_W-1:0]   rd_row [MAX_LEN];

  logic                v1;
  logic [SLOT_W-1:0]   slot1;
  logic [LEN_W-1:0]    len1;

  logic                v2;
  logic [SLOT_W-1:0]   slot2;
  logic [LEN_W-1:0]    len2;
  logic [BYTE_W-1:0]   row2 [MAX_LEN];
  logic [POS_W-1:0]    win_idx [MAX_LEN];
  logic [MAX_LEN-1:0]  cmp_ok;
  logic                hit;

  logic [SLOTS-1:0]    mask;
  logic [LEN_W-1:0]    len_tab [SLOTS];
  logic [SLOT_W-1:0]   first;
  logic [SLOTS-1:0]    rest;
  logic                pop;

  logic                out_valid;
  logic [mpm_pkg::OUT_SLOT_W-1:0] out_slot;
  logic [OFF_W-1:0]    out_offset;
  logic                out_last;

  // Input beat decode.
  assign items.ready   = cmd.take;
  assign acc           = items.valid && cmd.take;
  assign acc_load      = acc && (items.operation == mpm_pkg::OP_LOAD);
  assign acc_scan      = acc && (items.operation == mpm_pkg::OP_SCAN);
  assign acc_start     = acc && (items.operation == mpm_pkg::OP_START);
  assign load_in_range = (int'(items.pattern_slot) < SLOTS) &&
                         (int'(items.pattern_pos) < MAX_LEN);
  assign folded_in     = mpm_pkg::fold(items.byte_value);

  // Pattern bank: one RAM per byte position, all read at the same slot row.
  assign ram_waddr = cmd.clear_we ? cmd.addr : SLOT_W'(items.pattern_slot);
  assign ram_wdata = cmd.clear_we ? '0 : folded_in;

  for (genvar j = 0; j < MAX_LEN; j++) begin : g_bank
    assign ram_we[j] = cmd.clear_we ||
                       (acc_load && load_in_range && (int'(items.pattern_pos) == j));
    mpm_ram #(.WIDTH(BYTE_W), .DEPTH(SLOTS)) u_ram (
      .clk   (clk),
      .we    (ram_we[j]),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (cmd.addr),
      .rdata (rd_row[j])
    );
  end

  // Recent-byte window (index 0 newest, stored folded) and saturating count.
  always_ff @(posedge clk) begin
    if (rst || acc_start) begin
      for (int k = 0; k < MAX_LEN; k++) begin
        recent[k] <= '0;
      end
      bytes_seen <= '0;
    end else if (acc_scan) begin
      recent[0] <= folded_in;
      for (int k = 1; k < MAX_LEN; k++) begin
        recent[k] <= recent[k-1];
      end
      if (bytes_seen != '1) begin
        bytes_seen <= bytes_seen + 1'b1;
      end
    end
  end

  // Stage 1: pattern length is the position of the first zero byte.
  always_comb begin
    len1 = LEN_W'(MAX_LEN);
    for (int j = MAX_LEN - 1; j >= 0; j--) begin
      if (rd_row[j] == '0) begin
        len1 = LEN_W'(j);
      end
    end
  end

  // Stage 2: align pattern byte j with window byte len-1-j.
  always_comb begin
    for (int j = 0; j < MAX_LEN; j++) begin
      win_idx[j] = POS_W'(len2 - LEN_W'(j + 1));
      cmp_ok[j]  = (LEN_W'(j) >= len2) || (row2[j] == recent[win_idx[j]]);
    end
  end

  assign hit = v2 && (len2 != '0) && (bytes_seen >= OFF_W'(len2)) && (&cmp_ok);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.scan_issue;
      v2 <= v1;
    end
    slot1 <= cmd.addr;
    slot2 <= slot1;
    len2  <= len1;
    for (int j = 0; j < MAX_LEN; j++) begin
      row2[j] <= rd_row[j];
    end
  end

  // Lowest pending slot goes out first.
  always_comb begin
    first = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (mask[s]) begin
        first = SLOT_W'(s);
      end
    end
  end

  assign rest = mask & ~(SLOTS'(1) << first);
  assign pop  = cmd.emit_en && (mask != '0) && (!out_valid || results.ready);

  always_ff @(posedge clk) begin
    if (rst || acc_scan) begin
      mask <= '0;
    end else if (hit) begin
      mask[slot2] <= 1'b1;
    end else if (pop) begin
      mask <= rest;
    end
    if (v2) begin
      len_tab[slot2] <= len2;
    end
  end

  // Result register: holds a beat until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
    if (pop) begin
      out_slot   <= mpm_pkg::OUT_SLOT_W'(first);
      out_offset <= bytes_seen - OFF_W'(len_tab[first]);
      out_last   <= (rest == '0);
    end
  end

  assign results.valid        = out_valid;
  assign results.match_slot   = out_slot;
  assign results.match_offset = out_offset;
  assign results.last_match   = out_last;

  assign stat.item_valid = items.valid;
  assign stat.item_scan  = (items.operation == mpm_pkg::OP_SCAN);
  assign stat.pipe_busy  = v1 || v2;
  assign stat.mask_empty = (mask == '0);

endmodule
